// ----- rtl/onewire_master_slot_engine_core_defines.svh -----
// Shared assertion macros for the single-wire master slot engine.
`ifndef ONEWIRE_MASTER_SLOT_ENGINE_CORE_DEFINES_SVH
`define ONEWIRE_MASTER_SLOT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define OWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("owm check failed");

// Next-cycle implication, held off during reset.
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("owm check failed");

`endif

// ----- rtl/owm_pkg.sv -----
`timescale 1ns / 1ps
package owm_pkg;

	localparam int unsigned TICK_W      = 10;
	localparam int unsigned NREG        = 8;
	localparam int unsigned REG_IDX_W   = 3;
	localparam int unsigned LEAD_HIGH_TICKS = 2;

	// Command codes on the tick channel
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Bus drive codes
	localparam logic [1:0] DRV_REL  = 2'd0;
	localparam logic [1:0] DRV_LOW  = 2'd1;
	localparam logic [1:0] DRV_HIGH = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_RST_HIGH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RST_LOW   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PRES_WAIT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RST_TAIL  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WR_LOW    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RD_LOW    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_RD_SAMPLE = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SLOT_HOLD = 3'd7;

	localparam logic [TICK_W-1:0] REG_RESET_VALS [NREG] = '{
		10'd200, 10'd600, 10'd60, 10'd300, 10'd10, 10'd2, 10'd5, 10'd60
	};

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic       line_level;
	} owm_in_t;

	typedef struct packed {
		logic [1:0] bus_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       no_presence;
	} owm_out_t;

	// Classified tick as it travels from front to back
	typedef struct packed {
		logic       start_reset;
		logic       start_write;
		logic       start_read;
		logic [7:0] load_byte;
		logic       line_level;
	} owm_item_t;

	// Queue status seen by the front
	typedef struct packed {
		logic full;
		logic not_empty;
	} owm_qstat_t;

endpackage

// ----- rtl/owm_front.sv -----
`timescale 1ns / 1ps
module owm_front (
	input  logic                 tick_valid,
	output logic                 tick_stall,
	input  owm_pkg::owm_in_t     tick,
	input  owm_pkg::owm_qstat_t  qstat,
	output logic                 push,
	output owm_pkg::owm_item_t   push_item
);

	assign tick_stall = qstat.full;
	assign push       = tick_valid & ~qstat.full;

	// Decode the command into start flags; shift preload is data on write, zero on read.
	always_comb begin
		push_item             = '0;
		push_item.line_level  = tick.line_level;
		unique case (tick.cmd)
			owm_pkg::CMD_NONE: begin
			end
			owm_pkg::CMD_RESET: begin
				push_item.start_reset = 1'b1;
			end
			owm_pkg::CMD_WRITE: begin
				push_item.start_write = 1'b1;
				push_item.load_byte   = tick.data_byte;
			end
			default: begin
				push_item.start_read = 1'b1;
			end
		endcase
	end

endmodule

// ----- rtl/owm_queue.sv -----
`timescale 1ns / 1ps
module owm_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  owm_pkg::owm_item_t   push_item,
	input  logic                 pop,
	output owm_pkg::owm_item_t   head,
	output owm_pkg::owm_qstat_t  qstat
);

	owm_pkg::owm_item_t             mem_q [owm_pkg::QDEPTH];
	logic [owm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [owm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [owm_pkg::QPTR_W:0]       count_q;

	assign head            = mem_q[rd_ptr_q];
	assign qstat.not_empty = (count_q != '0);
	assign qstat.full      = (count_q == (owm_pkg::QPTR_W+1)'(owm_pkg::QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/owm_back.sv -----
`timescale 1ns / 1ps
module owm_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  owm_pkg::owm_item_t                 head,
	input  owm_pkg::owm_qstat_t                qstat,
	output logic                               pop,
	output logic                               result_valid,
	input  logic                               result_stall,
	output owm_pkg::owm_out_t                  result,
	input  logic                               cfg_valid,
	input  logic [owm_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [owm_pkg::TICK_W-1:0]         cfg_data
);

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_RHIGH = 4'd1;
	localparam logic [3:0] PH_RLOW  = 4'd2;
	localparam logic [3:0] PH_RWAIT = 4'd3;
	localparam logic [3:0] PH_RTAIL = 4'd4;
	localparam logic [3:0] PH_WLEAD = 4'd5;
	localparam logic [3:0] PH_WLOW  = 4'd6;
	localparam logic [3:0] PH_WHOLD = 4'd7;
	localparam logic [3:0] PH_DLEAD = 4'd8;
	localparam logic [3:0] PH_DLOW  = 4'd9;
	localparam logic [3:0] PH_DWAIT = 4'd10;
	localparam logic [3:0] PH_DHOLD = 4'd11;

	localparam logic [owm_pkg::TICK_W-1:0] LEAD_LEN = owm_pkg::TICK_W'(owm_pkg::LEAD_HIGH_TICKS);

	logic [owm_pkg::TICK_W-1:0] cfg_q [owm_pkg::NREG];

	logic [3:0]                  phase_q;
	logic [owm_pkg::TICK_W-1:0]  tick_cnt_q;
	logic [2:0]                  bit_idx_q;
	logic [7:0]                  shift_q;
	logic                        pres_q;
	logic [7:0]                  last_rd_q;
	logic                        res_valid_q;
	owm_pkg::owm_out_t           res_q;

	logic [3:0]                  ph_n;
	logic [owm_pkg::TICK_W-1:0]  tc_n;
	logic [owm_pkg::TICK_W-1:0]  len;
	logic [2:0]                  bi_n;
	logic [7:0]                  sb_n;
	logic                        pf_n;
	logic [7:0]                  lr_n;
	owm_pkg::owm_out_t           res_n;

	function automatic logic [owm_pkg::TICK_W-1:0] len_of(input logic [owm_pkg::TICK_W-1:0] v);
		return (v == '0) ? owm_pkg::TICK_W'(1) : v;
	endfunction

	// Output register frees up when empty or being taken this cycle
	assign pop          = qstat.not_empty & (~res_valid_q | ~result_stall);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		ph_n  = phase_q;
		tc_n  = tick_cnt_q;
		bi_n  = bit_idx_q;
		sb_n  = shift_q;
		pf_n  = pres_q;
		lr_n  = last_rd_q;
		len   = LEAD_LEN;
		res_n = '0;

		// Command start, only from idle
		if (phase_q == PH_IDLE) begin
			tc_n = '0;
			bi_n = '0;
			priority if (head.start_reset) begin
				ph_n = (cfg_q[owm_pkg::REG_RST_HIGH] == '0) ? PH_RLOW : PH_RHIGH;
			end else if (head.start_write) begin
				ph_n = PH_WLEAD;
				sb_n = head.load_byte;
			end else if (head.start_read) begin
				ph_n = PH_DLEAD;
				sb_n = head.load_byte;
			end else begin
				tc_n = tick_cnt_q;
				bi_n = bit_idx_q;
			end
		end

		if (ph_n != PH_IDLE) begin
			res_n.busy_res = 1'b1;
			unique case (ph_n)
				PH_RHIGH, PH_WLEAD, PH_DLEAD: res_n.bus_drive = owm_pkg::DRV_HIGH;
				PH_RLOW, PH_WLOW, PH_DLOW:    res_n.bus_drive = owm_pkg::DRV_LOW;
				PH_WHOLD: res_n.bus_drive = sb_n[0] ? owm_pkg::DRV_HIGH : owm_pkg::DRV_LOW;
				default:  res_n.bus_drive = owm_pkg::DRV_REL;
			endcase

			unique case (ph_n)
				PH_RHIGH:           len = len_of(cfg_q[owm_pkg::REG_RST_HIGH]);
				PH_RLOW:            len = len_of(cfg_q[owm_pkg::REG_RST_LOW]);
				PH_RWAIT:           len = len_of(cfg_q[owm_pkg::REG_PRES_WAIT]);
				PH_RTAIL:           len = len_of(cfg_q[owm_pkg::REG_RST_TAIL]);
				PH_WLOW:            len = len_of(cfg_q[owm_pkg::REG_WR_LOW]);
				PH_DLOW:            len = len_of(cfg_q[owm_pkg::REG_RD_LOW]);
				PH_DWAIT:           len = len_of(cfg_q[owm_pkg::REG_RD_SAMPLE]);
				PH_WHOLD, PH_DHOLD: len = len_of(cfg_q[owm_pkg::REG_SLOT_HOLD]);
				default:            len = LEAD_LEN;
			endcase

			tc_n = tc_n + owm_pkg::TICK_W'(1);
			if (tc_n >= len) begin
				tc_n = '0;
				unique case (ph_n)
					PH_RHIGH: ph_n = PH_RLOW;
					PH_RLOW:  ph_n = PH_RWAIT;
					PH_RWAIT: begin
						pf_n = head.line_level;
						if (cfg_q[owm_pkg::REG_RST_TAIL] == '0) begin
							res_n.done_res = 1'b1;
							ph_n           = PH_IDLE;
						end else begin
							ph_n = PH_RTAIL;
						end
					end
					PH_RTAIL: begin
						res_n.done_res = 1'b1;
						ph_n           = PH_IDLE;
					end
					PH_WLEAD: ph_n = PH_WLOW;
					PH_WLOW:  ph_n = PH_WHOLD;
					PH_WHOLD: begin
						sb_n = sb_n >> 1;
						if (bi_n == 3'd7) begin
							res_n.done_res = 1'b1;
							ph_n           = PH_IDLE;
						end else begin
							bi_n = bi_n + 3'd1;
							ph_n = PH_WLEAD;
						end
					end
					PH_DLEAD: ph_n = PH_DLOW;
					PH_DLOW:  ph_n = PH_DWAIT;
					PH_DWAIT: begin
						if (head.line_level) begin
							sb_n = sb_n | (8'(1) << bi_n);
						end
						ph_n = PH_DHOLD;
					end
					PH_DHOLD: begin
						if (bi_n == 3'd7) begin
							lr_n           = sb_n;
							res_n.done_res = 1'b1;
							ph_n           = PH_IDLE;
						end else begin
							bi_n = bi_n + 3'd1;
							ph_n = PH_DLEAD;
						end
					end
					default: ph_n = PH_IDLE;
				endcase
			end
		end

		res_n.read_byte   = lr_n;
		res_n.no_presence = pf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < owm_pkg::NREG; i++) begin
				cfg_q[i] <= owm_pkg::REG_RESET_VALS[i];
			end
			phase_q     <= PH_IDLE;
			tick_cnt_q  <= '0;
			bit_idx_q   <= '0;
			shift_q     <= '0;
			pres_q      <= 1'b0;
			last_rd_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cfg_q[cfg_index] <= cfg_data;
			end
			if (pop) begin
				phase_q     <= ph_n;
				tick_cnt_q  <= tc_n;
				bit_idx_q   <= bi_n;
				shift_q     <= sb_n;
				pres_q      <= pf_n;
				last_rd_q   <= lr_n;
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

endmodule

// ----- rtl/onewire_master_slot_engine_core.sv -----
`timescale 1ns / 1ps
// Single-wire bus master, one timing tick per beat.
// Tick channel (tick_valid/tick_stall/tick): each beat carries cmd, data_byte
// and the sampled line level for one bus tick. A command is taken only while
// the engine is idle; it is ignored while busy.
// Result channel (result_valid/result_stall/result): exactly one beat per tick,
// in order: bus drive code, busy, done, last read byte, presence flag.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes one of the
// eight 10-bit timing registers; always ready. Write only while idle.
// An accepted tick is written into the queue; its result reaches the output
// register when the back engine pops it. Throughput: one tick per cycle while
// result_stall is low, set by the back engine's phase/counter update.
// Reset clears the engine to idle, queue empty, timing registers to defaults.
// A stalled result holds; a four-entry queue between front and back absorbs
// ticks, and tick_stall rises only when that queue is full.
module onewire_master_slot_engine_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick_valid,
	output logic                            tick_stall,
	input  owm_pkg::owm_in_t                tick,
	output logic                            result_valid,
	input  logic                            result_stall,
	output owm_pkg::owm_out_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [owm_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [owm_pkg::TICK_W-1:0]      cfg_data
);

	owm_pkg::owm_qstat_t qstat;
	owm_pkg::owm_item_t  push_item;
	owm_pkg::owm_item_t  head;
	logic                push;
	logic                pop;

	// Timing registers live in the back engine and take writes every cycle.
	assign cfg_ready = 1'b1;

	// Front: accept and classify ticks
	owm_front u_front (
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.qstat      (qstat),
		.push       (push),
		.push_item  (push_item)
	);

	// Decoupling queue
	owm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// Back: slot engine plus output register
	owm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

endmodule

// ----- rtl/owm_checker.sv -----
`timescale 1ns / 1ps
`include "onewire_master_slot_engine_core_defines.svh"
module owm_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick_valid,
	input  logic                            tick_stall,
	input  owm_pkg::owm_in_t                tick,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  owm_pkg::owm_out_t               result,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [owm_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [owm_pkg::TICK_W-1:0]      cfg_data
);

	`OWM_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))

	`OWM_ASSERT_NOW(a_done_busy, clk, arst_n, result_valid && result.done_res, result.busy_res)

	`OWM_ASSERT_NOW(a_idle_release, clk, arst_n, result_valid && !result.busy_res, result.bus_drive == owm_pkg::DRV_REL)

	`OWM_ASSERT_NOW(a_drive_code, clk, arst_n, result_valid, result.bus_drive != 2'd3)

	`OWM_ASSERT_NEXT(a_read_byte_stable, clk, arst_n, result_valid && !result_stall && !result.done_res, !result_valid || result.done_res || $stable(result.read_byte))

endmodule

bind onewire_master_slot_engine_core owm_checker u_owm_checker (.*);
